>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the active transaction table.
// All checks are sampled on the rising clock edge and are switched off
// while the synchronous reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every sampled edge.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/matt_pkg.sv
`default_nettype none

package matt_pkg;

   // Number of table entries, one cell each.
   localparam int MAX_TRANSACTIONS = 16;

   localparam int OP_W  = 3;
   localparam int TID_W = 64;
   localparam int XID_W = 63;
   localparam int ST_W  = 3;

   localparam int REQ_BITS = OP_W + TID_W + 3 * XID_W;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = ST_W + XID_W + 3;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_BEGIN_MANUAL  = 3'd0,
      OP_BEGIN_AUTO    = 3'd1,
      OP_COMMIT_MANUAL = 3'd2,
      OP_COMMIT_AUTO   = 3'd3,
      OP_ROLLBACK      = 3'd4,
      OP_CHECK_VISIBLE = 3'd5,
      OP_CURRENT_XID   = 3'd6
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK     = 3'd0,
      ST_EXISTS = 3'd1,
      ST_NONE   = 3'd2,
      ST_MODE   = 3'd3,
      ST_FULL   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE    = 2'd0,
      S_COMPARE = 2'd1,
      S_UPDATE  = 2'd2
   } state_type;

   // Request as broadcast to every cell.
   typedef struct packed {
      op_type            op;
      logic [TID_W-1:0]  thread_id;
      logic [XID_W-1:0]  new_xid;
      logic [XID_W-1:0]  row_created;
      logic [XID_W-1:0]  row_expired;
   } req_type;

   // Summary handed from one cell to the next along the chain.
   typedef struct packed {
      logic              free_seen;     // a free slot exists at or below this point
      logic              owner_found;
      logic [XID_W-1:0]  owner_xid;
      logic              owner_auto;
      logic              owner_cx_eq;   // created id equals the caller's id
      logic              owner_ex_eq;   // expired id equals the caller's id
      logic              cx_active;
      logic              ex_active;
      logic              any_valid;
      logic              other_valid;   // valid entries other than the caller's
   } link_type;

   // Table update command broadcast to every cell.
   typedef struct packed {
      logic begin_en;
      logic auto_flag;
      logic free_en;
   } upd_type;

endpackage

`default_nettype wire

>>> src/matt_cell.sv
`default_nettype none

// One table entry. The compare results against the current request are
// registered in the compare cycle and folded into the chain summary.
module matt_cell (
   input  logic               clock,
   input  logic               reset,
   input  matt_pkg::req_type  req,
   input  logic               cmp_en,
   input  matt_pkg::upd_type  upd,
   input  matt_pkg::link_type link_in,
   output matt_pkg::link_type link_out
);

   logic                       valid_ff, valid_in;
   logic [matt_pkg::XID_W-1:0] xid_ff, xid_in;
   logic [matt_pkg::TID_W-1:0] thread_ff, thread_in;
   logic                       auto_ff, auto_in;
   logic                       own_hit_ff, own_hit_in;
   logic                       cx_hit_ff, cx_hit_in;
   logic                       ex_hit_ff, ex_hit_in;
   logic                       slot_sel;

   // The lowest free cell is the one with no free cell before it.
   assign slot_sel = !valid_ff && !link_in.free_seen;

   always_comb begin
      valid_in   = valid_ff;
      xid_in     = xid_ff;
      thread_in  = thread_ff;
      auto_in    = auto_ff;
      own_hit_in = own_hit_ff;
      cx_hit_in  = cx_hit_ff;
      ex_hit_in  = ex_hit_ff;
      if (cmp_en) begin
         own_hit_in = valid_ff && (thread_ff == req.thread_id);
         cx_hit_in  = valid_ff && (xid_ff == req.row_created);
         ex_hit_in  = valid_ff && (xid_ff == req.row_expired);
      end
      if (upd.begin_en && slot_sel) begin
         valid_in  = 1'b1;
         xid_in    = req.new_xid;
         thread_in = req.thread_id;
         auto_in   = upd.auto_flag;
      end
      if (upd.free_en && own_hit_ff) begin
         valid_in = 1'b0;
      end
   end

   always_comb begin
      link_out.free_seen   = link_in.free_seen | !valid_ff;
      link_out.owner_found = link_in.owner_found | own_hit_ff;
      link_out.owner_xid   = link_in.owner_xid | (own_hit_ff ? xid_ff : '0);
      link_out.owner_auto  = link_in.owner_auto | (own_hit_ff & auto_ff);
      link_out.owner_cx_eq = link_in.owner_cx_eq | (own_hit_ff & cx_hit_ff);
      link_out.owner_ex_eq = link_in.owner_ex_eq | (own_hit_ff & ex_hit_ff);
      link_out.cx_active   = link_in.cx_active | cx_hit_ff;
      link_out.ex_active   = link_in.ex_active | ex_hit_ff;
      link_out.any_valid   = link_in.any_valid | valid_ff;
      link_out.other_valid = link_in.other_valid | (valid_ff & !own_hit_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      xid_ff     <= xid_in;
      thread_ff  <= thread_in;
      auto_ff    <= auto_in;
      own_hit_ff <= own_hit_in;
      cx_hit_ff  <= cx_hit_in;
      ex_hit_ff  <= ex_hit_in;
   end

endmodule

`default_nettype wire

>>> src/mvcc_active_transaction_table_unit.sv
// Active transaction table for multi-version row visibility. Each request
// (begin manual or auto, commit manual or auto, rollback, visibility check,
// current id fetch) gives exactly one response transfer. The table is a
// chain of identical cells, one per entry; a request goes through a compare
// cycle and an update cycle: in the compare cycle every cell matches the
// caller's thread id and the row's created and expired ids against its own
// entry and registers the hits, and in the update cycle the hits ripple
// down the chain to find the caller, the lowest free slot and the active
// ids, the table is written and the response register is loaded. A new
// request is taken while idle or in the update cycle, so the next request
// is accepted as the current one completes. The response register is the
// only buffer on the output side; while it holds an untaken response the
// update cycle waits, and so does the next request. A begin goes to the
// lowest free entry and is refused when the thread already owns one or the
// table is full; the table comes out of reset empty with no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module mvcc_active_transaction_table_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // op[2:0], thread_id[66:3], new_xid[129:67], row created id[192:130],
   // row expired id[255:193]
   input  logic [matt_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // status[2:0], xid_out[65:3], visible[66], deleted[67], any_active[68],
   // zero padding above
   output logic [matt_pkg::RSP_W-1:0]  rsp_tdata
);

   localparam int TID_LO = matt_pkg::OP_W;
   localparam int NXID_LO = TID_LO + matt_pkg::TID_W;
   localparam int CXID_LO = NXID_LO + matt_pkg::XID_W;
   localparam int EXID_LO = CXID_LO + matt_pkg::XID_W;
   localparam int NCELL = matt_pkg::MAX_TRANSACTIONS;

   // Control and request registers.
   matt_pkg::state_type         state_ff, state_in;
   matt_pkg::req_type           req_ff, req_in;
   logic                        cx_eq_ex_ff, cx_eq_ex_in;
   logic                        ex_zero_ff, ex_zero_in;

   // Response register.
   logic                        rsp_tvalid_ff, rsp_tvalid_in;
   matt_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic [matt_pkg::XID_W-1:0]  rsp_xid_ff, rsp_xid_in;
   logic                        rsp_visible_ff, rsp_visible_in;
   logic                        rsp_deleted_ff, rsp_deleted_in;
   logic                        rsp_any_ff, rsp_any_in;

   logic                        accept;
   logic                        finish;
   logic                        cmp_en;
   matt_pkg::upd_type           upd_dec;
   matt_pkg::upd_type           upd;
   matt_pkg::status_type        status_dec;
   logic [matt_pkg::XID_W-1:0]  xid_dec;
   logic                        visible_dec;
   logic                        deleted_dec;
   logic                        any_dec;
   matt_pkg::link_type          link [NCELL+1];
   matt_pkg::link_type          chain_end;

   assign accept = req_tvalid && req_tready;

   // Incoming request fields; a fresh request is captured on every transfer.
   always_comb begin
      req_in = req_ff;
      if (accept) begin
         req_in.op          = matt_pkg::op_type'(req_tdata[matt_pkg::OP_W-1:0]);
         req_in.thread_id   = req_tdata[NXID_LO-1:TID_LO];
         req_in.new_xid     = req_tdata[CXID_LO-1:NXID_LO];
         req_in.row_created = req_tdata[EXID_LO-1:CXID_LO];
         req_in.row_expired = req_tdata[EXID_LO+matt_pkg::XID_W-1:EXID_LO];
      end
   end

   // State machine: idle, compare, update. The update cycle completes only
   // when the response register is free or being emptied in the same cycle.
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      finish     = 1'b0;
      cmp_en     = 1'b0;
      unique case (state_ff)
         matt_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = matt_pkg::S_COMPARE;
            end
         end
         matt_pkg::S_COMPARE: begin
            cmp_en   = 1'b1;
            state_in = matt_pkg::S_UPDATE;
         end
         matt_pkg::S_UPDATE: begin
            finish     = !rsp_tvalid_ff || rsp_tready;
            req_tready = finish;
            if (finish) begin
               state_in = req_tvalid ? matt_pkg::S_COMPARE : matt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = matt_pkg::S_IDLE;
         end
      endcase
   end

   // Row id relations that do not depend on the table are settled in the
   // compare cycle so that the update cycle only combines single bits.
   always_comb begin
      cx_eq_ex_in = cx_eq_ex_ff;
      ex_zero_in  = ex_zero_ff;
      if (cmp_en) begin
         cx_eq_ex_in = (req_ff.row_created == req_ff.row_expired);
         ex_zero_in  = (req_ff.row_expired == '0);
      end
   end

   // The chain of cells. The head of the chain starts with an empty summary.
   assign link[0] = '0;

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      matt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .req      (req_ff),
         .cmp_en   (cmp_en),
         .upd      (upd),
         .link_in  (link[i]),
         .link_out (link[i+1])
      );
   end

   assign chain_end = link[NCELL];

   // Request decode on the chain summary.
   always_comb begin
      upd_dec     = '0;
      status_dec  = matt_pkg::ST_OK;
      xid_dec     = '0;
      visible_dec = 1'b0;
      deleted_dec = 1'b0;
      unique case (req_ff.op) inside
         matt_pkg::OP_BEGIN_MANUAL, matt_pkg::OP_BEGIN_AUTO: begin
            if (chain_end.owner_found) begin
               status_dec = matt_pkg::ST_EXISTS;
               xid_dec    = chain_end.owner_xid;
            end else if (!chain_end.free_seen) begin
               status_dec = matt_pkg::ST_FULL;
            end else begin
               upd_dec.begin_en  = 1'b1;
               upd_dec.auto_flag = (req_ff.op == matt_pkg::OP_BEGIN_AUTO);
               xid_dec           = req_ff.new_xid;
            end
         end
         matt_pkg::OP_COMMIT_MANUAL, matt_pkg::OP_COMMIT_AUTO, matt_pkg::OP_ROLLBACK: begin
            if (!chain_end.owner_found) begin
               status_dec = matt_pkg::ST_NONE;
            end else begin
               xid_dec = chain_end.owner_xid;
               // Only an auto commit may close an auto entry; rollback is
               // for manual entries.
               if (chain_end.owner_auto != (req_ff.op == matt_pkg::OP_COMMIT_AUTO)) begin
                  status_dec = matt_pkg::ST_MODE;
               end else begin
                  upd_dec.free_en = 1'b1;
               end
            end
         end
         matt_pkg::OP_CHECK_VISIBLE: begin
            deleted_dec = !ex_zero_ff;
            if (!chain_end.owner_found) begin
               status_dec = matt_pkg::ST_NONE;
            end else begin
               xid_dec = chain_end.owner_xid;
               // Own live row, another transaction's committed live row, or a
               // row whose deleter is some other still active transaction.
               visible_dec =
                  (chain_end.owner_cx_eq && ex_zero_ff) ||
                  (!chain_end.owner_cx_eq && !chain_end.cx_active && ex_zero_ff) ||
                  (!ex_zero_ff && !chain_end.owner_ex_eq && chain_end.ex_active &&
                   !cx_eq_ex_ff);
            end
         end
         matt_pkg::OP_CURRENT_XID: begin
            if (!chain_end.owner_found) begin
               status_dec = matt_pkg::ST_NONE;
            end else begin
               xid_dec = chain_end.owner_xid;
            end
         end
         default: begin
            // Unused code: no operation.
         end
      endcase

      if (upd_dec.begin_en) begin
         any_dec = 1'b1;
      end else if (upd_dec.free_en) begin
         any_dec = chain_end.other_valid;
      end else begin
         any_dec = chain_end.any_valid;
      end
   end

   // The table is written only when the response is actually loaded.
   always_comb begin
      upd          = upd_dec;
      upd.begin_en = upd_dec.begin_en && finish;
      upd.free_en  = upd_dec.free_en && finish;
   end

   // Response register.
   always_comb begin
      rsp_tvalid_in  = rsp_tvalid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_xid_in     = rsp_xid_ff;
      rsp_visible_in = rsp_visible_ff;
      rsp_deleted_in = rsp_deleted_ff;
      rsp_any_in     = rsp_any_ff;
      if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (finish) begin
         rsp_tvalid_in  = 1'b1;
         rsp_status_in  = status_dec;
         rsp_xid_in     = xid_dec;
         rsp_visible_in = visible_dec;
         rsp_deleted_in = deleted_dec;
         rsp_any_in     = any_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= matt_pkg::S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      cx_eq_ex_ff    <= cx_eq_ex_in;
      ex_zero_ff     <= ex_zero_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_xid_ff     <= rsp_xid_in;
      rsp_visible_ff <= rsp_visible_in;
      rsp_deleted_ff <= rsp_deleted_in;
      rsp_any_ff     <= rsp_any_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(matt_pkg::RSP_W - matt_pkg::RSP_BITS){1'b0}},
                        rsp_any_ff, rsp_deleted_ff, rsp_visible_ff,
                        rsp_xid_ff, rsp_status_ff};

   // A successful begin leaves at least one entry in the table.
   `ASSERT_NEXT(a_begin_fills, upd.begin_en, chain_end.any_valid, "begin left the table empty")

   // Freeing an entry needs a caller found on the chain.
   `ASSERT_SAME(a_free_owner, upd.free_en, chain_end.owner_found, "free without an owner")

   // A full table cannot be empty.
   `ASSERT_SAME(a_full_busy, (state_ff == matt_pkg::S_UPDATE) && !chain_end.free_seen,
                chain_end.any_valid, "table reported full while empty")

   // No request is taken while the compare cycle is running.
   `ASSERT_SAME(a_no_take_cmp, state_ff == matt_pkg::S_COMPARE, !req_tready,
                "request taken during compare")

   // Begin and free never happen together.
   `ASSERT_ALWAYS(a_one_update, !(upd.begin_en && upd.free_en), "begin and free together")

endmodule

`default_nettype wire
